// ===== rtl/svps_pkg.sv =====
// Shared types and constants of the sound voice priority selector.
package svps_pkg;

  localparam int HANDLE_W = 16;
  localparam int SCORE_W  = 32;
  localparam int SQR_W    = 32;
  localparam int DIST_W   = 16;
  localparam int PRIO_W   = 8;
  localparam int KIND_W   = 2;
  localparam int RANK_W   = 4;
  localparam int FRAC_W   = 8;

  // priority * gain fits in GAIN_W bits, the Q15.8 numerator in NUM_W bits
  localparam int SCORE_GAIN = 100;
  localparam int GAIN_W     = 15;
  localparam int NUM_W      = GAIN_W + FRAC_W;
  localparam int PROD_W     = NUM_W + SQR_W;
  // every in-band quotient is at most the numerator, so NUM_W bits suffice
  localparam int QUO_W      = NUM_W;

  localparam logic [SCORE_W-1:0] SCORE_SAT = '1;

  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t KIND_REJECT = 2'd0;
  localparam kind_t KIND_EVICT  = 2'd1;
  localparam kind_t KIND_SELECT = 2'd2;

  typedef struct packed {
    logic [SQR_W-1:0]  sqr_distance;
    logic [DIST_W-1:0] near_dist;
    logic [DIST_W-1:0] far_dist;
    logic [PRIO_W-1:0] priority_req;
  } score_req_t;

  typedef enum logic [3:0] {
    SC_IDLE,
    SC_SQN,
    SC_SQF,
    SC_CLASS,
    SC_MUL,
    SC_DLOAD,
    SC_DIV1,
    SC_DIV2,
    SC_DONE
  } score_state_t;

  typedef enum logic [1:0] {
    SEL_IDLE,
    SEL_SCORE,
    SEL_INSERT,
    SEL_EMIT
  } sel_state_t;

endpackage

// ===== rtl/sound_voice_priority_select.sv =====
// Sound voice priority selector: scores candidates and keeps a sorted voice list.
// Candidate: no division when none is needed (inside near, beyond far, zero priority or
// zero distance), one divider pass with equal near and far squares, two in band. A
// result, if any, strobes in the first cycle with busy low; the next request is taken
// at the end of that cycle. End of frame: busy while entries leave the list head, one
// per cycle, each result in the next cycle, none if empty. Sync rst_n empties the list.
module sound_voice_priority_select #(
  parameter int MAX_SELECTED = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_func,
  input  logic [svps_pkg::HANDLE_W-1:0]     in_sound_handle,
  input  logic [svps_pkg::SQR_W-1:0]        in_sqr_distance,
  input  logic [svps_pkg::DIST_W-1:0]       in_near_dist,
  input  logic [svps_pkg::DIST_W-1:0]       in_far_dist,
  input  logic [svps_pkg::PRIO_W-1:0]       in_priority_req,
  output logic                              out_valid,
  output logic [svps_pkg::KIND_W-1:0]       out_kind,
  output logic [svps_pkg::HANDLE_W-1:0]     out_handle,
  output logic [svps_pkg::SCORE_W-1:0]      out_score,
  output logic [svps_pkg::RANK_W-1:0]       out_rank,
  output logic                              out_last
);

  localparam int IW = (MAX_SELECTED > 1) ? $clog2(MAX_SELECTED) : 1;
  localparam int CW = $clog2(MAX_SELECTED + 1);

  svps_pkg::sel_state_t state_r, state_nxt;

  logic [CW-1:0]                   count_r, count_nxt;
  logic [IW-1:0]                   idx_r, idx_nxt;
  logic [svps_pkg::HANDLE_W-1:0]   handle_r, handle_nxt;
  logic [svps_pkg::SCORE_W-1:0]    sc_r, sc_nxt;

  logic [svps_pkg::HANDLE_W-1:0]   hnd_r [MAX_SELECTED];
  logic [svps_pkg::SCORE_W-1:0]    scr_r [MAX_SELECTED];

  logic                            out_valid_r, out_valid_nxt;
  svps_pkg::kind_t                 out_kind_r, out_kind_nxt;
  logic [svps_pkg::HANDLE_W-1:0]   out_handle_r, out_handle_nxt;
  logic [svps_pkg::SCORE_W-1:0]    out_score_r, out_score_nxt;
  logic [svps_pkg::RANK_W-1:0]     out_rank_r, out_rank_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            do_insert, do_shift;
  logic                            full, emit_last;
  logic [MAX_SELECTED-1:0]         ge;
  logic [MAX_SELECTED:0]           ge_sh;
  logic [MAX_SELECTED-1:0]         ge_prev;

  logic                            sc_go, sc_done;
  logic [svps_pkg::SCORE_W-1:0]    sc_score;
  svps_pkg::score_req_t            sc_req;

  assign busy  = (state_r != svps_pkg::SEL_IDLE);
  assign sc_go = start && !busy && !in_func;

  assign sc_req.sqr_distance = in_sqr_distance;
  assign sc_req.near_dist    = in_near_dist;
  assign sc_req.far_dist     = in_far_dist;
  assign sc_req.priority_req = in_priority_req;

  svps_score u_score (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (sc_go),
    .req   (sc_req),
    .done  (sc_done),
    .score (sc_score)
  );

  // each live entry compares against the new score; sorted list makes ge a prefix
  always_comb begin
    for (int i = 0; i < MAX_SELECTED; i++) begin
      ge[i] = (CW'(i) < count_r) && (scr_r[i] >= sc_r);
    end
  end

  assign ge_sh     = {ge, 1'b1};
  assign ge_prev   = ge_sh[MAX_SELECTED-1:0];
  assign full      = (count_r == CW'(MAX_SELECTED));
  assign emit_last = ((CW'(idx_r) + CW'(1)) == count_r);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    handle_nxt     = handle_r;
    sc_nxt         = sc_r;
    do_insert      = 1'b0;
    do_shift       = 1'b0;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = svps_pkg::KIND_REJECT;
    out_handle_nxt = handle_r;
    out_score_nxt  = '0;
    out_rank_nxt   = '0;
    out_last_nxt   = 1'b0;
    case (state_r)
      svps_pkg::SEL_IDLE: begin
        if (start) begin
          if (in_func) begin
            idx_nxt = '0;
            if (count_r != '0) begin
              state_nxt = svps_pkg::SEL_EMIT;
            end
          end else begin
            handle_nxt = in_sound_handle;
            state_nxt  = svps_pkg::SEL_SCORE;
          end
        end
      end
      svps_pkg::SEL_SCORE: begin
        if (sc_done) begin
          sc_nxt    = sc_score;
          state_nxt = svps_pkg::SEL_INSERT;
        end
      end
      svps_pkg::SEL_INSERT: begin
        state_nxt = svps_pkg::SEL_IDLE;
        if (sc_r == '0) begin
          out_valid_nxt = 1'b1;
        end else begin
          do_insert = 1'b1;
          if (full) begin
            // drop the lowest entry, which may be the new one
            out_valid_nxt = 1'b1;
            out_kind_nxt  = svps_pkg::KIND_EVICT;
            if (ge[MAX_SELECTED-1]) begin
              out_score_nxt = sc_r;
            end else begin
              out_handle_nxt = hnd_r[MAX_SELECTED-1];
              out_score_nxt  = scr_r[MAX_SELECTED-1];
            end
          end else begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      svps_pkg::SEL_EMIT: begin
        do_shift       = 1'b1;
        out_valid_nxt  = 1'b1;
        out_kind_nxt   = svps_pkg::KIND_SELECT;
        out_handle_nxt = hnd_r[0];
        out_score_nxt  = scr_r[0];
        out_rank_nxt   = svps_pkg::RANK_W'(idx_r);
        out_last_nxt   = emit_last;
        idx_nxt        = idx_r + IW'(1);
        if (emit_last) begin
          count_nxt = '0;
          state_nxt = svps_pkg::SEL_IDLE;
        end
      end
      default: begin
        state_nxt = svps_pkg::SEL_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svps_pkg::SEL_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    handle_r     <= handle_nxt;
    sc_r         <= sc_nxt;
    out_kind_r   <= out_kind_nxt;
    out_handle_r <= out_handle_nxt;
    out_score_r  <= out_score_nxt;
    out_rank_r   <= out_rank_nxt;
    out_last_r   <= out_last_nxt;
  end

  // list cells: insert shifts toward the tail, emit shifts toward the head
  for (genvar i = 0; i < MAX_SELECTED; i++) begin : g_cell
    logic [svps_pkg::HANDLE_W-1:0] up_h, dn_h;
    logic [svps_pkg::SCORE_W-1:0]  up_s, dn_s;

    if (i == 0) begin : g_head
      assign up_h = handle_r;
      assign up_s = sc_r;
    end else begin : g_body
      assign up_h = hnd_r[i-1];
      assign up_s = scr_r[i-1];
    end

    if (i == MAX_SELECTED - 1) begin : g_tail
      assign dn_h = hnd_r[i];
      assign dn_s = scr_r[i];
    end else begin : g_next
      assign dn_h = hnd_r[i+1];
      assign dn_s = scr_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (do_insert && !ge[i]) begin
        hnd_r[i] <= ge_prev[i] ? handle_r : up_h;
        scr_r[i] <= ge_prev[i] ? sc_r : up_s;
      end else if (do_shift) begin
        hnd_r[i] <= dn_h;
        scr_r[i] <= dn_s;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_handle = out_handle_r;
  assign out_score  = out_score_r;
  assign out_rank   = out_rank_r;
  assign out_last   = out_last_r;

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == svps_pkg::SEL_INSERT || state_r == svps_pkg::SEL_EMIT))
    else $error("result strobe without insert or emit step");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_SELECTED))
    else $error("list count beyond capacity");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> (out_valid_r && out_kind_r == svps_pkg::KIND_SELECT && count_r == '0
                    && state_r == svps_pkg::SEL_IDLE))
    else $error("final emit did not empty the list");

  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == svps_pkg::SEL_INSERT && sc_r != '0 && !full)
      |=> (count_r == $past(count_r) + CW'(1) && !out_valid_r))
    else $error("insert into non-full list did not grow it cleanly");

endmodule

// ===== rtl/svps_score.sv =====
// Iterative score unit: one shared multiplier and one shared restoring divider step.
module svps_score (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  svps_pkg::score_req_t            req,
  output logic                            done,
  output logic [svps_pkg::SCORE_W-1:0]    score
);

  localparam int CNT_W = $clog2(svps_pkg::QUO_W);

  svps_pkg::score_state_t state_r, state_nxt;

  logic [svps_pkg::SQR_W-1:0]   d_r, d_nxt;
  logic [svps_pkg::DIST_W-1:0]  n_r, n_nxt;
  logic [svps_pkg::DIST_W-1:0]  f_r, f_nxt;
  logic [svps_pkg::PRIO_W-1:0]  p_r, p_nxt;
  logic [svps_pkg::NUM_W-1:0]   num_r, num_nxt;
  logic [svps_pkg::SQR_W-1:0]   n2_r, n2_nxt;
  logic [svps_pkg::SQR_W-1:0]   den_r, den_nxt;
  logic [svps_pkg::SQR_W-1:0]   fd_r, fd_nxt;
  logic [2*svps_pkg::SQR_W-1:0] prod_r, prod_nxt;
  logic [svps_pkg::SQR_W-1:0]   rem_r, rem_nxt;
  logic [svps_pkg::QUO_W-1:0]   dq_r, dq_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [svps_pkg::SCORE_W-1:0] score_r, score_nxt;

  logic [svps_pkg::SQR_W-1:0]   mul_a, mul_b;
  logic [svps_pkg::SQR_W-1:0]   divisor;
  logic [svps_pkg::SQR_W:0]     trial, diff;
  logic                         qbit;
  logic [svps_pkg::SQR_W-1:0]   rem_step;
  logic [svps_pkg::QUO_W-1:0]   dq_step;
  logic [svps_pkg::SQR_W-1:0]   f2;
  logic [svps_pkg::GAIN_W-1:0]  gain_p;

  assign f2     = prod_r[svps_pkg::SQR_W-1:0];
  assign gain_p = svps_pkg::GAIN_W'(req.priority_req) * svps_pkg::GAIN_W'(svps_pkg::SCORE_GAIN);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      svps_pkg::SC_SQN: begin
        mul_a = svps_pkg::SQR_W'(n_r);
        mul_b = svps_pkg::SQR_W'(n_r);
      end
      svps_pkg::SC_SQF: begin
        mul_a = svps_pkg::SQR_W'(f_r);
        mul_b = svps_pkg::SQR_W'(f_r);
      end
      svps_pkg::SC_MUL: begin
        mul_a = svps_pkg::SQR_W'(num_r);
        mul_b = fd_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = {{svps_pkg::SQR_W{1'b0}}, mul_a} * {{svps_pkg::SQR_W{1'b0}}, mul_b};

  // shared restoring divider step
  assign divisor  = (state_r == svps_pkg::SC_DIV1) ? den_r : d_r;
  assign trial    = {rem_r, dq_r[svps_pkg::QUO_W-1]};
  assign diff     = trial - {1'b0, divisor};
  assign qbit     = (trial >= {1'b0, divisor});
  assign rem_step = qbit ? diff[svps_pkg::SQR_W-1:0] : trial[svps_pkg::SQR_W-1:0];
  assign dq_step  = {dq_r[svps_pkg::QUO_W-2:0], qbit};

  always_comb begin
    state_nxt = state_r;
    d_nxt     = d_r;
    n_nxt     = n_r;
    f_nxt     = f_r;
    p_nxt     = p_r;
    num_nxt   = num_r;
    n2_nxt    = n2_r;
    den_nxt   = den_r;
    fd_nxt    = fd_r;
    rem_nxt   = rem_r;
    dq_nxt    = dq_r;
    cnt_nxt   = cnt_r;
    score_nxt = score_r;
    case (state_r)
      svps_pkg::SC_IDLE: begin
        if (go) begin
          d_nxt     = req.sqr_distance;
          n_nxt     = req.near_dist;
          f_nxt     = req.far_dist;
          p_nxt     = req.priority_req;
          num_nxt   = {gain_p, {svps_pkg::FRAC_W{1'b0}}};
          state_nxt = svps_pkg::SC_SQN;
        end
      end
      svps_pkg::SC_SQN: begin
        state_nxt = svps_pkg::SC_SQF;
      end
      svps_pkg::SC_SQF: begin
        n2_nxt    = prod_r[svps_pkg::SQR_W-1:0];
        state_nxt = svps_pkg::SC_CLASS;
      end
      svps_pkg::SC_CLASS: begin
        state_nxt = svps_pkg::SC_DONE;
        if (d_r < n2_r) begin
          score_nxt = svps_pkg::SCORE_W'({p_r, {svps_pkg::FRAC_W{1'b0}}});
        end else if (d_r > f2) begin
          score_nxt = '0;
        end else if (p_r == '0) begin
          score_nxt = '0;
        end else if (d_r == '0) begin
          score_nxt = svps_pkg::SCORE_SAT;
        end else begin
          den_nxt   = f2 - n2_r;
          fd_nxt    = f2 - d_r;
          state_nxt = svps_pkg::SC_MUL;
        end
      end
      svps_pkg::SC_MUL: begin
        state_nxt = svps_pkg::SC_DLOAD;
      end
      svps_pkg::SC_DLOAD: begin
        cnt_nxt = '0;
        if (den_r == '0) begin
          // equal near and far squares: fraction taken as one
          rem_nxt   = '0;
          dq_nxt    = num_r;
          state_nxt = svps_pkg::SC_DIV2;
        end else begin
          // upper product bits are already below the divisor
          rem_nxt   = prod_r[svps_pkg::PROD_W-1 -: svps_pkg::SQR_W];
          dq_nxt    = prod_r[svps_pkg::QUO_W-1:0];
          state_nxt = svps_pkg::SC_DIV1;
        end
      end
      svps_pkg::SC_DIV1: begin
        dq_nxt  = dq_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(svps_pkg::QUO_W - 1)) begin
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = svps_pkg::SC_DIV2;
        end
      end
      svps_pkg::SC_DIV2: begin
        dq_nxt  = dq_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(svps_pkg::QUO_W - 1)) begin
          score_nxt = svps_pkg::SCORE_W'(dq_step);
          state_nxt = svps_pkg::SC_DONE;
        end
      end
      svps_pkg::SC_DONE: begin
        state_nxt = svps_pkg::SC_IDLE;
      end
      default: begin
        state_nxt = svps_pkg::SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svps_pkg::SC_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    n_r     <= n_nxt;
    f_r     <= f_nxt;
    p_r     <= p_nxt;
    num_r   <= num_nxt;
    n2_r    <= n2_nxt;
    den_r   <= den_nxt;
    fd_r    <= fd_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    dq_r    <= dq_nxt;
    cnt_r   <= cnt_nxt;
    score_r <= score_nxt;
  end

  assign done  = (state_r == svps_pkg::SC_DONE);
  assign score = score_r;

endmodule
